// File: rtl/rasc_pkg.sv
// Shared types, constants and the rotate-add step function for the
// rotate-add stream cipher. No dependencies.
`default_nettype none

package rasc_pkg;

  typedef logic [31:0]       word_t;
  typedef logic [15:0][31:0] block_t;

  typedef struct packed {
    logic [7:0] data_in;
    logic       restart;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       last_out;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  index;
    logic [63:0] data;
  } cfg_wr_t;

  // back part -> keystream generator
  typedef struct packed {
    logic restart;  // reload working state from the registers
    logic next;     // current block used up
  } ks_ctl_t;

  localparam logic [2:0] CFG_KEY_LOW      = 3'd0;
  localparam logic [2:0] CFG_KEY_MID_LOW  = 3'd1;
  localparam logic [2:0] CFG_KEY_MID_HIGH = 3'd2;
  localparam logic [2:0] CFG_KEY_HIGH     = 3'd3;
  localparam logic [2:0] CFG_NONCE_LOW    = 3'd4;
  localparam logic [2:0] CFG_NONCE_HIGH   = 3'd5;
  localparam logic [2:0] CFG_START_CTR    = 3'd6;

  // Working state after reset: all zero except the four mixing constants.
  localparam block_t RESET_WORK = {
    256'h0,
    32'he2275686, 32'h07963435, 32'h35024727, 32'hf6078754,
    128'h0
  };

  // Word indices per step, most significant first; 0..3 oblique, 4..7 vertical.
  localparam logic [3:0] STEP_WORDS [8][4] = '{
    '{4'd0,  4'd5,  4'd10, 4'd15},
    '{4'd4,  4'd9,  4'd14, 4'd3},
    '{4'd8,  4'd13, 4'd2,  4'd7},
    '{4'd12, 4'd1,  4'd6,  4'd11},
    '{4'd0,  4'd4,  4'd8,  4'd12},
    '{4'd1,  4'd5,  4'd9,  4'd13},
    '{4'd2,  4'd6,  4'd10, 4'd14},
    '{4'd3,  4'd7,  4'd11, 4'd15}
  };

  localparam logic [6:0] STEP_ROT [8] = '{
    7'd17, 7'd23, 7'd71, 7'd73, 7'd41, 7'd53, 7'd31, 7'd47
  };

  // Rotate the 128-bit value left and add it back word by word.
  function automatic logic [127:0] rot_add4(logic [127:0] v, logic [6:0] r);
    logic [255:0] dbl;
    logic [127:0] rv;
    dbl = {v, v} << r;
    rv  = dbl[255:128];
    return {v[127:96] + rv[127:96], v[95:64] + rv[95:64],
            v[63:32] + rv[63:32], v[31:0] + rv[31:0]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/rasc_queue.sv
// Small first-in first-out queue of flat words.
// Depends on nothing; used for the input and result sides.
`default_nettype none

module rasc_queue #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rasc_keygen.sv
// Keystream generator: configuration registers, working state and a
// half-round unit that iterates over the rounds. Depends on rasc_pkg.
`default_nettype none

module rasc_keygen
  import rasc_pkg::*;
#(
  parameter int ROUND_COUNT = 10
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_wr_t cfg,
  input  ks_ctl_t ctl,
  output logic    ks_valid,
  output block_t  ks_block
);

  localparam int HALF_COUNT = 2 * ROUND_COUNT;
  localparam int HALF_W     = $clog2(HALF_COUNT);

  typedef enum logic [1:0] {ST_LOAD, ST_RUN, ST_DONE} gen_state_t;

  gen_state_t       state_r;
  logic [HALF_W-1:0] half_r;
  block_t           x_r;
  block_t           work_r;
  block_t           blk_r;
  logic             blk_valid_r;

  logic [63:0] key_r [4];
  logic [63:0] nonce_low_r;
  word_t       nonce_high_r;
  word_t       start_ctr_r;

  block_t       init_blk;
  block_t       init_work;
  block_t       obl_blk;
  block_t       ver_blk;
  logic [127:0] obl_sum;
  logic [127:0] ver_sum;
  logic         last_half;
  logic         blk_free;

  assign ks_valid  = blk_valid_r;
  assign ks_block  = blk_r;
  assign last_half = (half_r == HALF_W'(HALF_COUNT - 1));
  assign blk_free  = !blk_valid_r || ctl.next;

  // State loaded on restart; the working copy already points at the next block.
  always_comb begin
    init_blk    = RESET_WORK;
    init_blk[0] = start_ctr_r;
    init_blk[1] = nonce_low_r[31:0];
    init_blk[2] = nonce_low_r[63:32];
    init_blk[3] = nonce_high_r;
    for (int i = 0; i < 4; i++) begin
      init_blk[8 + 2 * i] = key_r[i][31:0];
      init_blk[9 + 2 * i] = key_r[i][63:32];
    end
    init_work    = init_blk;
    init_work[0] = init_blk[0] + 32'd1;
  end

  // Both half-rounds; the four steps of each touch disjoint words.
  always_comb begin
    obl_blk = x_r;
    ver_blk = x_r;
    obl_sum = '0;
    ver_sum = '0;
    for (int s = 0; s < 4; s++) begin
      obl_sum = rot_add4({x_r[STEP_WORDS[s][0]], x_r[STEP_WORDS[s][1]],
                          x_r[STEP_WORDS[s][2]], x_r[STEP_WORDS[s][3]]},
                         STEP_ROT[s]);
      obl_blk[STEP_WORDS[s][0]] = obl_sum[127:96];
      obl_blk[STEP_WORDS[s][1]] = obl_sum[95:64];
      obl_blk[STEP_WORDS[s][2]] = obl_sum[63:32];
      obl_blk[STEP_WORDS[s][3]] = obl_sum[31:0];
      ver_sum = rot_add4({x_r[STEP_WORDS[s+4][0]], x_r[STEP_WORDS[s+4][1]],
                          x_r[STEP_WORDS[s+4][2]], x_r[STEP_WORDS[s+4][3]]},
                         STEP_ROT[s+4]);
      ver_blk[STEP_WORDS[s+4][0]] = ver_sum[127:96];
      ver_blk[STEP_WORDS[s+4][1]] = ver_sum[95:64];
      ver_blk[STEP_WORDS[s+4][2]] = ver_sum[63:32];
      ver_blk[STEP_WORDS[s+4][3]] = ver_sum[31:0];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
      nonce_low_r  <= '0;
      nonce_high_r <= '0;
      start_ctr_r  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_KEY_LOW:      key_r[0]     <= cfg.data;
        CFG_KEY_MID_LOW:  key_r[1]     <= cfg.data;
        CFG_KEY_MID_HIGH: key_r[2]     <= cfg.data;
        CFG_KEY_HIGH:     key_r[3]     <= cfg.data;
        CFG_NONCE_LOW:    nonce_low_r  <= cfg.data;
        CFG_NONCE_HIGH:   nonce_high_r <= cfg.data[31:0];
        CFG_START_CTR:    start_ctr_r  <= cfg.data[31:0];
        default: ;
      endcase
    end
  end

  // Generator sequence and block hand-off.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      half_r      <= '0;
      work_r      <= RESET_WORK;
      blk_valid_r <= 1'b0;
    end else if (ctl.restart) begin
      x_r         <= init_blk;
      work_r      <= init_work;
      half_r      <= '0;
      blk_valid_r <= 1'b0;
      state_r     <= ST_RUN;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          x_r       <= work_r;
          work_r[0] <= work_r[0] + 32'd1;
          half_r    <= '0;
          state_r   <= ST_RUN;
          if (ctl.next) begin
            blk_valid_r <= 1'b0;
          end
        end
        ST_RUN: begin
          x_r    <= half_r[0] ? ver_blk : obl_blk;
          half_r <= half_r + 1'b1;
          if (last_half) begin
            state_r <= ST_DONE;
          end
          if (ctl.next) begin
            blk_valid_r <= 1'b0;
          end
        end
        ST_DONE: begin
          if (blk_free) begin
            blk_r       <= x_r;
            blk_valid_r <= 1'b1;
            x_r         <= work_r;
            work_r[0]   <= work_r[0] + 32'd1;
            half_r      <= '0;
            state_r     <= ST_RUN;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/rasc_back.sv
// Back part: takes queued items, applies keystream bytes, tracks the byte
// position and asks the generator for blocks and restarts. Depends on rasc_pkg.
`default_nettype none

module rasc_back
  import rasc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  head,
  input  logic      head_valid,
  output logic      head_pop,
  input  logic      ks_valid,
  input  block_t    ks_block,
  output ks_ctl_t   ctl,
  input  logic      out_full,
  output logic      out_push,
  output out_item_t out_item
);

  logic [5:0] pos_r;
  logic       rs_sent_r;
  logic       need_rs;
  logic       go;
  logic       blk_end;
  word_t      ks_word;
  word_t      ks_shift;

  assign need_rs  = head_valid && head.restart && !rs_sent_r;
  assign go       = head_valid && ks_valid && !out_full && !need_rs;
  assign blk_end  = head.last_in || (pos_r == 6'd63);

  assign ks_word  = ks_block[pos_r[5:2]];
  assign ks_shift = ks_word >> {pos_r[1:0], 3'b000};

  assign head_pop          = go;
  assign out_push          = go;
  assign out_item.data_out = head.data_in ^ ks_shift[7:0];
  assign out_item.last_out = head.last_in;

  assign ctl.restart = need_rs;
  assign ctl.next    = go && blk_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      rs_sent_r <= 1'b0;
    end else if (need_rs) begin
      pos_r     <= '0;
      rs_sent_r <= 1'b1;
    end else if (go) begin
      pos_r     <= blk_end ? 6'd0 : pos_r + 6'd1;
      rs_sent_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rotate_add_stream_cipher.sv
// Top level of the rotate-add stream cipher: input queue, keystream
// generator, back part and result queue. Depends on rasc_pkg and submodules.
//
//  channel  | handshake                         | payload
//  ---------+-----------------------------------+--------------------------
//  input    | in_push / in_full                 | in_item  (in_item_t)
//  result   | out_pop / out_empty               | out_item (out_item_t)
//  config   | cfg_valid / cfg_ready (always 1)  | cfg_index, cfg_data
//
// Sustained rate is one item per cycle while nothing stalls. The generator makes
// a 64-byte block with one half-round of four parallel rotate-add steps per cycle
// and keeps one finished block ahead of the one in use.
// An item with restart waits for a fresh block from the reloaded state; items with
// last_in closer together than the generator can make blocks wait for it too.
// Reset is synchronous; no clearing pass. Either side may stall on its own:
// the input and result queues decouple the back part from both neighbors.
`default_nettype none

module rotate_add_stream_cipher
  import rasc_pkg::*;
#(
  parameter int ROUND_COUNT = 10,
  parameter int IN_DEPTH    = 4,
  parameter int OUT_DEPTH   = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_push,
  output logic        in_full,
  input  in_item_t    in_item,
  // result items
  input  logic        out_pop,
  output logic        out_empty,
  output out_item_t   out_item,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  in_item_t  head;
  logic      head_empty;
  logic      head_pop;
  logic      ks_valid;
  block_t    ks_block;
  ks_ctl_t   ks_ctl;
  logic      res_full;
  logic      res_push;
  out_item_t res_item;
  cfg_wr_t   cfg;

  // Registers are plain flops; a write to a defined index always lands.
  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // Front: holds accepted items until the back part can use them.
  rasc_queue #(
    .WIDTH ($bits(in_item_t)),
    .DEPTH (IN_DEPTH)
  ) u_in_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (in_item),
    .full    (in_full),
    .pop     (head_pop),
    .rd_data (head),
    .empty   (head_empty)
  );

  // Round unit running one block ahead of consumption.
  rasc_keygen #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_keygen (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .ctl      (ks_ctl),
    .ks_valid (ks_valid),
    .ks_block (ks_block)
  );

  // XOR with keystream, byte position, restart and end-of-buffer handling.
  rasc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!head_empty),
    .head_pop   (head_pop),
    .ks_valid   (ks_valid),
    .ks_block   (ks_block),
    .ctl        (ks_ctl),
    .out_full   (res_full),
    .out_push   (res_push),
    .out_item   (res_item)
  );

  // Result queue: a finished item waits here while new ones keep coming.
  rasc_queue #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_item),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (out_item),
    .empty   (out_empty)
  );

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for rotate_add_stream_cipher: byte items go in under random
// stalls and every result is checked against an in-bench keystream predictor.
// Depends on rasc_pkg and the rotate_add_stream_cipher RTL.

module testbench;
  import rasc_pkg::*;

  localparam int ROUNDS          = 10;
  localparam int BLOCK_BYTES     = 64;
  localparam int DRAIN_CYCLES    = 2 * ROUNDS + 8;  // generator latency plus queue slack
  localparam int ITEMS_PER_PHASE = 250;
  localparam int PHASES          = 6;
  localparam int TIMEOUT_NS      = 12_000_000;      // several times the slowest run
  localparam int MAX_PRINTS      = 40;

  // Index past the last register: the block must drop the write.
  localparam logic [2:0] CFG_SPARE = 3'd7;

  // Word indices of the eight mix steps, four nibbles per step, first word in the
  // top nibble; step 0 in the low 16 bits.
  localparam logic [127:0] MIX_IDX =
    128'h37BF_26AE_159D_048C_C16B_8D27_49E3_05AF;

  // Mixing constants for working words 4..7, word 4 in the low 32 bits.
  localparam logic [127:0] MIX_CONST =
    {32'he2275686, 32'h07963435, 32'h35024727, 32'hf6078754};

  typedef struct {
    in_item_t item;
    bit       drain;  // hold this item back until every result has come
  } pending_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_push   = 1'b0;
  logic        in_full;
  in_item_t    in_item   = '0;
  logic        out_pop   = 1'b0;
  logic        out_empty;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data  = '0;

  rotate_add_stream_cipher #(
    .ROUND_COUNT (ROUNDS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  pending_t    feed_q [$];  // items waiting for the driver
  out_item_t   byte_q [$];  // predicted results, oldest first
  bit          in_taken;    // set at posedge when the driven item went in

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int unsigned n_errors     = 0;
  int unsigned n_items      = 0;
  int unsigned n_results    = 0;
  int unsigned n_restarts   = 0;
  int unsigned n_cfg_writes = 0;
  int unsigned n_blocks     = 0;
  int unsigned n_wraps      = 0;

  // Predictor copy of the cipher: registers, working words, current keystream block.
  logic [63:0] cipher_regs [7];
  word_t       work_words [16];
  word_t       ks_words [16];
  int unsigned ks_pos;

  // ---------------------------------------------------------------------------
  // Keystream predictor
  // ---------------------------------------------------------------------------
  function automatic int mix_rot(input int s);
    case (s)
      0:       return 17;
      1:       return 23;
      2:       return 71;
      3:       return 73;
      4:       return 41;
      5:       return 53;
      6:       return 31;
      default: return 47;
    endcase
  endfunction

  // Working words from the registers: counter, nonce, constants, key.
  function automatic void load_work_words();
    int i;
    work_words[0] = cipher_regs[CFG_START_CTR][31:0];
    work_words[1] = cipher_regs[CFG_NONCE_LOW][31:0];
    work_words[2] = cipher_regs[CFG_NONCE_LOW][63:32];
    work_words[3] = cipher_regs[CFG_NONCE_HIGH][31:0];
    for (i = 0; i < 4; i++) begin
      work_words[4 + i]     = MIX_CONST[32*i +: 32];
      work_words[8 + 2 * i] = cipher_regs[i][31:0];
      work_words[9 + 2 * i] = cipher_regs[i][63:32];
    end
  endfunction

  // Four words read as one 128-bit value, rotated left, added back word by word.
  function automatic void mix_step(input int s);
    logic [3:0]   idx [4];
    logic [127:0] v;
    logic [127:0] rv;
    int           r;
    int           k;
    r = mix_rot(s);
    for (k = 0; k < 4; k++) begin
      idx[k] = MIX_IDX[16*s + 4*(3-k) +: 4];
      v[32*(3-k) +: 32] = ks_words[idx[k]];
    end
    rv = (v << r) | (v >> (128 - r));
    for (k = 0; k < 4; k++)
      ks_words[idx[k]] = ks_words[idx[k]] + rv[32*(3-k) +: 32];
  endfunction

  function automatic void make_keystream_block();
    int i;
    int r;
    for (i = 0; i < 16; i++)
      ks_words[i] = work_words[i];
    for (r = 0; r < ROUNDS; r++)
      for (i = 0; i < 8; i++)
        mix_step(i);
    if (work_words[0] == 32'hFFFF_FFFF)
      n_wraps++;
    work_words[0] = work_words[0] + 32'd1;
    ks_pos = 0;
    n_blocks++;
  endfunction

  // Expected result for one accepted item; advances the predictor state.
  function automatic out_item_t cipher_byte(input in_item_t it);
    out_item_t res;
    word_t     w;
    if (it.restart) begin
      load_work_words();
      ks_pos = BLOCK_BYTES;
    end
    if (ks_pos >= BLOCK_BYTES)
      make_keystream_block();
    w = ks_words[ks_pos / 4];
    res.data_out = it.data_in ^ w[8*(ks_pos % 4) +: 8];
    res.last_out = it.last_in;
    ks_pos++;
    // end of buffer drops the rest of the block
    if (it.last_in)
      ks_pos = BLOCK_BYTES;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (n_errors < MAX_PRINTS)
      $display("[%0t] MISMATCH %s: got %h, want %h", $time, what, got, want);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: takes the next item from feed_q at the falling edge. An item stays
  // on the port until a rising edge sees push high and full low.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : feeder
    logic     push_nxt;
    pending_t head;
    push_nxt = in_push && !in_taken;
    if (rst_n && !push_nxt && feed_q.size() != 0 &&
        !(feed_q[0].drain && byte_q.size() != 0) &&
        $urandom_range(99) >= send_idle_pct) begin
      head = feed_q.pop_front();
      in_item <= head.item;
      push_nxt = 1'b1;
    end
    in_push <= push_nxt;
  end

  // Receiver side: pop is raised at random, independent of empty.
  always @(negedge clk) begin
    out_pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge, check a popped result against the oldest
  // prediction, then predict for an item accepted at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    out_item_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        n_results++;
        if (byte_q.size() == 0) begin
          report_mismatch("result with nothing pending", out_item.data_out, 8'h00);
        end else begin
          want = byte_q.pop_front();
          if (out_item.data_out !== want.data_out)
            report_mismatch("data_out", out_item.data_out, want.data_out);
          if (out_item.last_out !== want.last_out)
            report_mismatch("last_out", {7'd0, out_item.last_out}, {7'd0, want.last_out});
        end
      end
      if (in_push && !in_full) begin
        byte_q.push_back(cipher_byte(in_item));
        in_taken = 1'b1;
        n_items++;
        if (in_item.restart)
          n_restarts++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] d, input logic rs, input logic last,
                            input bit drain);
    pending_t p;
    p.item.data_in = d;
    p.item.restart = rs;
    p.item.last_in = last;
    p.drain        = drain;
    feed_q.push_back(p);
  endtask

  // Everything queued has gone in and every result has come out.
  task automatic wait_idle();
    do @(negedge clk);
    while (feed_q.size() != 0 || in_push || byte_q.size() != 0);
  endtask

  // Valid stays high across back-to-back writes; the caller lowers it.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_NONCE_HIGH || idx == CFG_START_CTR)
      cipher_regs[idx] = {32'h0, val[31:0]};
    else if (idx != CFG_SPARE)
      cipher_regs[idx] = val;
    n_cfg_writes++;
  endtask

  // One full setting: all seven registers plus a dropped write to the spare index.
  task automatic write_all(input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3,
                           input logic [63:0] n0, input logic [63:0] n1,
                           input logic [63:0] ctr);
    write_reg(CFG_KEY_LOW,      k0);
    write_reg(CFG_KEY_MID_LOW,  k1);
    write_reg(CFG_KEY_MID_HIGH, k2);
    write_reg(CFG_KEY_HIGH,     k3);
    write_reg(CFG_NONCE_LOW,    n0);
    write_reg(CFG_NONCE_HIGH,   n1);
    write_reg(CFG_START_CTR,    ctr);
    write_reg(CFG_SPARE,        {$urandom, $urandom});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int   i;
    int   p;
    int   k;
    int   len;
    int   n_queued;
    logic rs;

    // predictor at reset: registers zero, fresh block needed
    for (i = 0; i < 7; i++)
      cipher_regs[i] = '0;
    load_work_words();
    for (i = 0; i < 16; i++)
      ks_words[i] = '0;
    ks_pos = BLOCK_BYTES;

    send_idle_pct = 25;
    recv_idle_pct = 73;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset state, no restart needed before the first byte.
    queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h5A, 1'b0, 1'b1, 1'b0);  // end of buffer drops the block
    queue_byte(8'hA5, 1'b0, 1'b0, 1'b0);
    wait_idle();

    // Upper halves of the 32-bit registers carry junk that must be dropped;
    // counter one step before wrap.
    write_all('1, 64'h0123_4567_89AB_CDEF, '1, 64'h8000_0000_0000_0001,
              '1, 64'hA5A5_A5A5_FFFF_FFFF, 64'h1234_5678_FFFF_FFFF);
    queue_byte(8'h3C, 1'b0, 1'b0, 1'b0);  // new registers not live yet
    queue_byte(8'hFF, 1'b1, 1'b0, 1'b0);  // restart at counter all ones
    queue_byte(8'h00, 1'b0, 1'b1, 1'b0);
    queue_byte(8'h81, 1'b0, 1'b0, 1'b0);  // counter has wrapped to zero
    queue_byte(8'h7E, 1'b1, 1'b1, 1'b0);  // restart and last on one item
    queue_byte(8'hFF, 1'b0, 1'b1, 1'b0);
    queue_byte(8'h00, 1'b1, 1'b0, 1'b0);
    for (k = 0; k < 12; k++)
      queue_byte(8'($urandom_range(255)), 1'b0, k == 11, 1'b0);
    wait_idle();

    // Random phases: buffers of random length, most well formed with a final
    // last_in, some noise restarts and early ends in between.
    for (p = 0; p < PHASES; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      case (p)
        0: write_all('0, '0, '0, '0, '0, '0, 64'h0000_0000_FFFF_FFFE);
        1: write_all('1, '1, '1, '1, '1, '1, '1);
        3: write_all(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                     {$urandom, 32'hFFFF_FFFF});
        default: write_all(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                           rand64());
      endcase

      n_queued = 0;
      while (n_queued < ITEMS_PER_PHASE) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(65, 200) : $urandom_range(1, 64);
        rs  = ($urandom_range(2) == 0);
        for (k = 0; k < len; k++) begin
          // one item mid-phase waits for the result queue to run dry
          queue_byte(8'($urandom_range(255)),
                     (k == 0) ? rs : ($urandom_range(99) == 0),
                     (k == len - 1) ? ($urandom_range(7) != 0) : ($urandom_range(99) == 0),
                     n_queued == ITEMS_PER_PHASE / 2);
          n_queued++;
        end
      end
      wait_idle();
    end

    // Anything arriving now has no prediction and is flagged by the monitor.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d byte items, %0d restarts, %0d register writes over %0d phases.",
             n_items, n_restarts, n_cfg_writes, PHASES + 1);
    $display("Predicted %0d keystream blocks with %0d counter wraps; %0d results checked.",
             n_blocks, n_wraps, n_results);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout with %0d results outstanding", byte_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
